>>> src/upe_pkg.sv
// shared types, prefix table and helpers for the url prefix extractor
`timescale 1ns / 1ps

package upe_pkg;

  localparam int NumPrefixes = 6;
  localparam int WinLen      = 8;
  localparam int HistDepth   = 7;
  localparam int PfxW        = 3;
  localparam int PosW        = 3;

  // prefix text, left aligned, zero padded
  localparam logic [7:0] PrefixText [NumPrefixes][WinLen] = '{
    '{"f", "t", "p", ":", "/", "/", 8'h00, 8'h00},
    '{"h", "t", "t", "p", ":", "/", "/", 8'h00},
    '{"h", "t", "t", "p", "s", ":", "/", "/"},
    '{"m", "a", "i", "l", "t", "o", ":", 8'h00},
    '{"n", "e", "w", "s", ":", 8'h00, 8'h00, 8'h00},
    '{"t", "e", "l", "n", "e", "t", ":", 8'h00}
  };

  localparam logic [3:0] PrefixLen [NumPrefixes] = '{
    4'd6, 4'd7, 4'd8, 4'd7, 4'd5, 4'd7
  };

  localparam logic [5:0] EnableReset = 6'h3f;

  typedef enum logic [1:0] {
    JobByte   = 2'd0,
    JobEnd    = 2'd1,
    JobPrefix = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e       kind;
    logic [7:0]      data;
    logic [PfxW-1:0] pfx;
  } job_t;

  // front to queue
  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  // queue to back
  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

  function automatic logic [7:0] prefix_char(logic [PfxW-1:0] id, logic [PosW-1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (id <= PfxW'(NumPrefixes - 1)) begin
      c = PrefixText[id][pos];
    end
    return c;
  endfunction

  function automatic logic [PosW-1:0] prefix_last(logic [PfxW-1:0] id);
    logic [PosW-1:0] l;
    l = '0;
    if (id <= PfxW'(NumPrefixes - 1)) begin
      l = PosW'(PrefixLen[id] - 4'd1);
    end
    return l;
  endfunction

endpackage

>>> src/upe_front.sv
// front end: history window, prefix matcher and url state
`timescale 1ns / 1ps

module upe_front import upe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output q_wr_t      q_wr_o
);

  logic [5:0]  enable_q;
  logic [7:0]  hist_q [HistDepth];
  logic [7:0]  win [WinLen];
  logic        inside_q, inside_d;
  logic [NumPrefixes-1:0] hit;
  logic [PfxW-1:0] pfx_sel;
  logic        url_byte;

  always_comb begin
    for (int i = 0; i < HistDepth; i++) begin
      win[i] = hist_q[i];
    end
    win[WinLen-1] = data_byte_i;
  end

  // compare the window tail against every enabled prefix
  always_comb begin
    logic ok;
    ok = 1'b0;
    for (int s = 0; s < NumPrefixes; s++) begin
      ok = enable_q[s];
      for (int k = 0; k < WinLen; k++) begin
        if (k < int'(PrefixLen[s])) begin
          if (win[WinLen - int'(PrefixLen[s]) + k] != PrefixText[s][k]) begin
            ok = 1'b0;
          end
        end
      end
      hit[s] = ok;
    end
  end

  // lowest numbered prefix wins
  always_comb begin
    pfx_sel = '0;
    for (int s = NumPrefixes - 1; s >= 0; s--) begin
      if (hit[s]) begin
        pfx_sel = PfxW'(s);
      end
    end
  end

  always_comb begin
    url_byte = 1'b0;
    if (data_byte_i inside {[8'h21:8'h7e]}) begin
      url_byte = !(data_byte_i inside {",", "<", ">"});
    end
  end

  always_comb begin
    q_wr_o.push     = 1'b0;
    q_wr_o.job.kind = JobByte;
    q_wr_o.job.data = data_byte_i;
    q_wr_o.job.pfx  = pfx_sel;
    inside_d        = inside_q;
    if (accept_i) begin
      if (end_of_input_i) begin
        q_wr_o.push     = inside_q;
        q_wr_o.job.kind = JobEnd;
        inside_d        = 1'b0;
      end else if (inside_q) begin
        q_wr_o.push = 1'b1;
        if (url_byte) begin
          q_wr_o.job.kind = JobByte;
        end else begin
          q_wr_o.job.kind = JobEnd;
          inside_d        = 1'b0;
        end
      end else if (|hit) begin
        q_wr_o.push     = 1'b1;
        q_wr_o.job.kind = JobPrefix;
        inside_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= EnableReset;
      inside_q <= 1'b0;
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= 8'h00;
      end
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      inside_q <= inside_d;
      if (accept_i) begin
        for (int i = 0; i < HistDepth; i++) begin
          hist_q[i] <= end_of_input_i ? 8'h00 : win[i+1];
        end
      end
    end
  end

  a_eoi_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_input_i |=> !inside_q)
    else $error("url still open after end of input");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_o.push |-> accept_i)
    else $error("queue push without an accepted item");

  a_prefix_only_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_o.push && q_wr_o.job.kind == JobPrefix |-> !inside_q && !end_of_input_i)
    else $error("prefix job issued inside a url");

endmodule

>>> src/upe_fifo.sv
// short job queue between front and back
`timescale 1ns / 1ps

module upe_fifo import upe_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  output logic  full_o,
  input  logic  pop_i,
  output q_rd_t q_rd_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign q_rd_o.valid = (count_q != '0);
  assign q_rd_o.job   = mem_q[rd_ptr_q];
  assign do_push      = q_wr_i.push && !full_o;
  assign do_pop       = pop_i && q_rd_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> src/upe_back.sv
// back end: expands jobs into result items behind an output register
`timescale 1ns / 1ps

module upe_back import upe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_rd_t      q_rd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] url_byte_o,
  output logic       first_of_url_o,
  output logic       url_end_o
);

  logic            advance;
  logic            busy_q, busy_d;
  logic [PosW-1:0] k_q, k_d;
  logic [PfxW-1:0] pfx_q, pfx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            first_q, first_d;
  logic            end_q, end_d;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !busy_q && q_rd_i.valid;

  always_comb begin
    busy_d      = busy_q;
    k_d         = k_q;
    pfx_d       = pfx_q;
    out_valid_d = out_valid_q && out_stall_i;
    byte_d      = byte_q;
    first_d     = first_q;
    end_d       = end_q;
    if (advance) begin
      if (busy_q) begin
        // rest of the prefix text
        out_valid_d = 1'b1;
        byte_d      = prefix_char(pfx_q, k_q);
        first_d     = 1'b0;
        end_d       = 1'b0;
        k_d         = k_q + 1'b1;
        if (k_q == prefix_last(pfx_q)) begin
          busy_d = 1'b0;
        end
      end else if (q_rd_i.valid) begin
        out_valid_d = 1'b1;
        case (q_rd_i.job.kind)
          JobEnd: begin
            byte_d  = 8'h00;
            first_d = 1'b0;
            end_d   = 1'b1;
          end
          JobPrefix: begin
            byte_d  = prefix_char(q_rd_i.job.pfx, '0);
            first_d = 1'b1;
            end_d   = 1'b0;
            pfx_d   = q_rd_i.job.pfx;
            k_d     = PosW'(1);
            busy_d  = 1'b1;
          end
          default: begin
            byte_d  = q_rd_i.job.data;
            first_d = 1'b0;
            end_d   = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    pfx_q   <= pfx_d;
    byte_q  <= byte_d;
    first_q <= first_d;
    end_q   <= end_d;
  end

  assign out_valid_o    = out_valid_q;
  assign url_byte_o     = byte_q;
  assign first_of_url_o = first_q;
  assign url_end_o      = end_q;

  a_busy_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> k_q != '0)
    else $error("prefix expansion at position zero while busy");

  a_first_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(first_q && end_q))
    else $error("result flagged both first and end");

endmodule

>>> src/url_prefix_extractor.sv
// top level of the url prefix extractor: front, job queue and back
// path: a job from an accepted item is registered in the queue, then its first result in the back end's output register
// throughput: one item per cycle unless in_stall_o; a prefix match puts out 5 to 8 items,
//   one per cycle unless out_stall_i, from the back end while the queue of QueueDepth jobs keeps taking input
// reset: asynchronous active low, clears history, url state, queue and output valid,
//   and sets all prefix enables
`timescale 1ns / 1ps

module url_prefix_extractor import upe_pkg::*; #(
  parameter int QueueDepth = 4  // jobs between front and back, at least 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: prefix enable mask
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] url_byte_o,
  output logic       first_of_url_o,
  output logic       url_end_o
);

  q_wr_t q_wr;   // job written by the front
  q_rd_t q_rd;   // head of the queue seen by the back
  logic  q_full;
  logic  pop;
  logic  accept;

  // input only waits when the job queue is full
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // front: keeps the seven byte history, matches prefixes and tracks
  // whether a url is open; emits at most one job per item
  upe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_wr_o         (q_wr)
  );

  // jobs wait here while the back spells out a prefix
  upe_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (pop),
    .q_rd_o (q_rd)
  );

  // back: one result item per cycle into the output register unless the output stalls
  upe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_rd_i         (q_rd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .url_byte_o     (url_byte_o),
    .first_of_url_o (first_of_url_o),
    .url_end_o      (url_end_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr.push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule
